// ===== hw/rtl/mptw_pkg.sv =====
// Shared types and constants for the multilevel page table walker.
`default_nettype none

package mptw_pkg;

    // Sizes of the stores and fields
    localparam int MAX_LEVELS      = 4;
    localparam int MAX_INDEX_BITS  = 4;
    localparam int NUM_TABLES      = 64;
    localparam int NUM_PROCESSES   = 16;
    localparam int FRAME_BITS      = 16;

    localparam int TID_W           = 6;
    localparam int PID_W           = 4;
    localparam int PAGE_W          = 16;
    localparam int SLOT_W          = MAX_INDEX_BITS;
    localparam int VALUE_W         = 16;
    localparam int READS_W         = 3;
    localparam int LVL_W           = 2;
    localparam int CFG_W           = 3;
    localparam int CFG_IDX_W       = 1;
    localparam int ENTRY_ADDR_W    = TID_W + SLOT_W;
    localparam int ENTRY_DEPTH     = NUM_TABLES << MAX_INDEX_BITS;

    // Stream word layout, input side (tdata)
    localparam int IN_PID_LSB      = 0;
    localparam int IN_PAGE_LSB     = IN_PID_LSB + PID_W;
    localparam int IN_TID_LSB      = IN_PAGE_LSB + PAGE_W;
    localparam int IN_SLOT_LSB     = IN_TID_LSB + TID_W;
    localparam int IN_PRES_LSB     = IN_SLOT_LSB + SLOT_W;
    localparam int IN_VALUE_LSB    = IN_PRES_LSB + 1;
    localparam int IN_DATA_W       = 48;
    localparam int OUT_DATA_W      = 24;

    // Item kinds
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_ROOT  = 2'd1,
        OP_XLATE = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    // Result codes
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_ROOT = 2'd1,
        STAT_MISSING = 2'd2,
        STAT_BAD     = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;       // clear one entry of the entry memory
        logic load;        // capture the input word, reset result fields
        logic wr_entry;    // write a table entry
        logic wr_root;     // write a root table slot
        logic no_root;     // flag missing root
        logic walk_start;  // issue first table read
        logic walk_step;   // evaluate read data, maybe issue next read
        logic out_load;    // move result into the output register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic    clr_done;
        opcode_t opcode;
        logic    root_valid;
        logic    walk_done;
        logic    out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mptw_ctrl.sv =====
// Controller state machine for the page table walker.
`default_nettype none

module mptw_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire mptw_pkg::dp_stat_t  stat,
    output mptw_pkg::ctrl_cmd_t      cmd
);
    import mptw_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_DECODE = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_RESULT;
                unique case (stat.opcode)
                    OP_WRITE: cmd.wr_entry = 1'b1;
                    OP_ROOT:  cmd.wr_root  = 1'b1;
                    OP_XLATE: begin
                        if (stat.root_valid) begin
                            cmd.walk_start = 1'b1;
                            state_next     = ST_WALK;
                        end else begin
                            cmd.no_root = 1'b1;
                        end
                    end
                    OP_NONE: ;
                    default: ;
                endcase
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                if (stat.walk_done) state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mptw_datapath.sv =====
// Datapath: config registers, root table, entry memory, walk logic, output register.
`default_nettype none

module mptw_datapath (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration writes
    input  wire logic                                  cfg_we,
    input  wire logic [mptw_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  wire logic [mptw_pkg::CFG_W-1:0]            cfg_data,
    // input word
    input  wire logic [mptw_pkg::IN_DATA_W-1:0]        in_data,
    input  wire logic [1:0]                            in_user,
    // result channel
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [mptw_pkg::OUT_DATA_W-1:0]            out_data,
    output logic [1:0]                                 out_user,
    // controller link
    input  wire mptw_pkg::ctrl_cmd_t                   cmd,
    output mptw_pkg::dp_stat_t                         stat
);
    import mptw_pkg::*;

    // Configuration, stored already clamped
    logic [CFG_W-1:0]         levels_reg, bits_reg;

    // Captured item
    opcode_t                  op_reg;
    logic [PID_W-1:0]         pid_reg;
    logic [PAGE_W-1:0]        page_reg;
    logic [TID_W-1:0]         tid_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic                     pres_reg;
    logic [VALUE_W-1:0]       value_reg;

    // Root table: valid bits reset, table ids not
    logic [NUM_PROCESSES-1:0] root_valid_reg;
    logic [TID_W-1:0]         root_tid_reg [NUM_PROCESSES];

    // Entry memory: {valid, value}
    logic [VALUE_W:0]         entry_mem [ENTRY_DEPTH];
    logic [VALUE_W:0]         rd_data_reg;
    logic [ENTRY_ADDR_W-1:0]  clr_cnt_reg;
    logic                     mem_we;
    logic [ENTRY_ADDR_W-1:0]  mem_waddr;
    logic [VALUE_W:0]         mem_wdata;
    logic                     mem_re;
    logic [ENTRY_ADDR_W-1:0]  mem_raddr;

    // Walk state and result
    logic [LVL_W-1:0]         lvl_reg;
    status_t                  res_status_reg;
    logic [FRAME_BITS-1:0]    res_frame_reg;
    logic [READS_W-1:0]       res_reads_reg;

    // Output register
    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic [FRAME_BITS-1:0]    out_frame_reg;
    logic [READS_W-1:0]       out_reads_reg;

    logic                     rd_valid;
    logic [VALUE_W-1:0]       rd_value;
    logic                     walk_last;
    logic                     walk_bad;
    logic                     walk_done;

    // Clamp a register value into 1..hi
    function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) r = CFG_W'(1);
        else if (v > hi) r = hi;
        return r;
    endfunction

    // Page number slice used at a given level, top level first
    function automatic logic [SLOT_W-1:0] slice_idx(input logic [LVL_W-1:0] lvl);
        logic [CFG_W-1:0]  rem;
        logic [3:0]        sh;
        logic [PAGE_W-1:0] shifted;
        logic [PAGE_W-1:0] mask;
        rem     = levels_reg - CFG_W'(1) - CFG_W'(lvl);
        sh      = 4'(bits_reg * rem);
        shifted = page_reg >> sh;
        mask    = (PAGE_W'(1) << bits_reg) - PAGE_W'(1);
        return SLOT_W'(shifted & mask);
    endfunction

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= CFG_W'(2);
            bits_reg   <= CFG_W'(2);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_LEVEL_COUNT: levels_reg <= clamp_cfg(cfg_data, CFG_W'(MAX_LEVELS));
                CFG_INDEX_BITS:  bits_reg   <= clamp_cfg(cfg_data, CFG_W'(MAX_INDEX_BITS));
                default: ;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= opcode_t'(in_user);
            pid_reg   <= in_data[IN_PID_LSB +: PID_W];
            page_reg  <= in_data[IN_PAGE_LSB +: PAGE_W];
            tid_reg   <= in_data[IN_TID_LSB +: TID_W];
            slot_reg  <= in_data[IN_SLOT_LSB +: SLOT_W];
            pres_reg  <= in_data[IN_PRES_LSB];
            value_reg <= in_data[IN_VALUE_LSB +: VALUE_W];
        end
    end

    // Root table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_valid_reg <= '0;
        end else if (cmd.wr_root) begin
            root_valid_reg[pid_reg] <= pres_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_root) root_tid_reg[pid_reg] <= tid_reg;
    end

    // Clearing sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear) begin
            clr_cnt_reg <= clr_cnt_reg + ENTRY_ADDR_W'(1);
        end
    end

    // Read data decode and walk outcome
    assign rd_valid  = rd_data_reg[VALUE_W];
    assign rd_value  = rd_data_reg[VALUE_W-1:0];
    assign walk_last = (CFG_W'(lvl_reg) == levels_reg - CFG_W'(1));
    assign walk_bad  = (rd_value >= VALUE_W'(NUM_TABLES));
    assign walk_done = !rd_valid || walk_last || walk_bad;

    // Memory port control
    always_comb begin
        mem_we    = cmd.clear || cmd.wr_entry;
        mem_waddr = cmd.clear ? clr_cnt_reg : {tid_reg, slot_reg};
        mem_wdata = cmd.clear ? '0 : {pres_reg, value_reg};
        mem_re    = cmd.walk_start || (cmd.walk_step && !walk_done);
        if (cmd.walk_start) begin
            mem_raddr = {root_tid_reg[pid_reg], slice_idx('0)};
        end else begin
            mem_raddr = {rd_value[TID_W-1:0], slice_idx(lvl_reg + LVL_W'(1))};
        end
    end

    // Entry memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) entry_mem[mem_waddr] <= mem_wdata;
        if (mem_re) rd_data_reg <= entry_mem[mem_raddr];
    end

    // Walk level and result fields
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            res_status_reg <= STAT_OK;
            res_frame_reg  <= '0;
            res_reads_reg  <= '0;
        end
        if (cmd.no_root) res_status_reg <= STAT_NO_ROOT;
        if (cmd.walk_start) lvl_reg <= '0;
        if (cmd.walk_step) begin
            res_reads_reg <= res_reads_reg + READS_W'(1);
            priority if (!rd_valid) begin
                res_status_reg <= STAT_MISSING;
            end else if (walk_last) begin
                res_frame_reg <= FRAME_BITS'(rd_value);
            end else if (walk_bad) begin
                res_status_reg <= STAT_BAD;
            end else begin
                lvl_reg <= lvl_reg + LVL_W'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_frame_reg  <= res_frame_reg;
            out_reads_reg  <= res_reads_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_user  = out_status_reg;
    assign out_data  = {{(OUT_DATA_W - FRAME_BITS - READS_W){1'b0}},
                        out_reads_reg, out_frame_reg};

    // Status to controller
    always_comb begin
        stat.clr_done   = (clr_cnt_reg == '1);
        stat.opcode     = op_reg;
        stat.root_valid = root_valid_reg[pid_reg];
        stat.walk_done  = walk_done;
        stat.out_free   = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/multilevel_page_table_walk.sv =====
// Top level of the multilevel page table walker.
// Usage:
//   Input words arrive on s_tvalid/s_tready; s_tuser carries the opcode (write
//   table entry, set process root, translate, or no-op). One result word per
//   input word leaves on m_tvalid/m_tready; m_tuser carries the status.
//   level_count and index_bits are written on the cfg channel while idle.
// Flow:
//   One word is handled at a time. Entry writes, root writes, no-ops and
//   translations without a root pass through the decode and result states; a
//   translation also walks the tables, up to 4 reads one after another, as the
//   entry memory gives one registered read per cycle and each level needs the
//   previous level's entry.
// Reset:
//   aresetn (synchronous, active low) invalidates all roots and starts a
//   sweep that invalidates all 1024 entries of the entry memory; s_tready stays low
//   during the sweep. The cfg channel is always ready.
// Backpressure:
//   A result waits in the output register while m_tready is low; the next word
//   is accepted and processed meanwhile and holds until the register frees.
`default_nettype none

module multilevel_page_table_walk (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // input stream
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // process_id[3:0], page_number[19:4], table_id[25:20], entry_index[29:26],
    // entry_present[30], entry_value[46:31], zero pad[47]
    input  wire logic [mptw_pkg::IN_DATA_W-1:0]         s_tdata,
    input  wire logic [1:0]                             s_tuser,   // opcode[1:0]
    // result stream
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // frame[15:0], table_reads[18:16], zero pad[23:19]
    output logic [mptw_pkg::OUT_DATA_W-1:0]             m_tdata,
    output logic [1:0]                                  m_tuser,   // status[1:0]
    // configuration writes
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [mptw_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  wire logic [mptw_pkg::CFG_W-1:0]             cfg_data
);
    import mptw_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    // Controller
    mptw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    mptw_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the multilevel page table walker.
`timescale 1ns / 1ps

module tb_top;
    import mptw_pkg::*;

    localparam int SLOTS = 1 << MAX_INDEX_BITS;

    // One input word, unpacked
    typedef struct {
        opcode_t               op;
        logic [PID_W-1:0]      pid;
        logic [PAGE_W-1:0]     page;
        logic [TID_W-1:0]      tid;
        logic [SLOT_W-1:0]     slot;
        logic                  present;
        logic [VALUE_W-1:0]    value;
    } walk_word_t;

    // One result word, unpacked
    typedef struct {
        status_t               status;
        logic [FRAME_BITS-1:0] frame;
        logic [READS_W-1:0]    reads;
    } walk_result_t;

    // A page that has a path built for it
    typedef struct {
        logic [PID_W-1:0]  pid;
        logic [PAGE_W-1:0] page;
    } mapped_page_t;

    // Shadow page tables plus the queue of result words still owed by the block
    class walk_scoreboard;
        bit                 entry_ok  [ENTRY_DEPTH];
        logic [VALUE_W-1:0] entry_val [ENTRY_DEPTH];
        bit                 root_ok   [NUM_PROCESSES];
        logic [TID_W-1:0]   root_id   [NUM_PROCESSES];
        logic [CFG_W-1:0]   level_reg;
        logic [CFG_W-1:0]   bits_reg;
        walk_result_t       owed_q [$];
        int                 errors;

        function new();
            for (int i = 0; i < ENTRY_DEPTH; i++) begin
                entry_ok[i]  = 1'b0;
                entry_val[i] = '0;
            end
            for (int i = 0; i < NUM_PROCESSES; i++) begin
                root_ok[i] = 1'b0;
                root_id[i] = '0;
            end
            level_reg = 3'd2;
            bits_reg  = 3'd2;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_LEVEL_COUNT) level_reg = val;
            else if (idx == CFG_INDEX_BITS) bits_reg = val;
        endfunction

        // Register values as the walk uses them, clamped to the legal range
        function int levels_used();
            if (level_reg < 1) return 1;
            if (level_reg > MAX_LEVELS) return MAX_LEVELS;
            return int'(level_reg);
        endfunction

        function int bits_used();
            if (bits_reg < 1) return 1;
            if (bits_reg > MAX_INDEX_BITS) return MAX_INDEX_BITS;
            return int'(bits_reg);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Apply one word to the shadow state and return what it should produce
        function walk_result_t apply_word(walk_word_t w);
            walk_result_t r;
            int levels, nbits, cur, idx, addr;
            r.status = STAT_OK;
            r.frame  = '0;
            r.reads  = '0;
            levels   = levels_used();
            nbits    = bits_used();
            case (w.op)
                OP_WRITE: begin
                    if (w.tid < NUM_TABLES) begin
                        addr = int'(w.tid) * SLOTS + int'(w.slot);
                        entry_ok[addr]  = w.present;
                        entry_val[addr] = w.value;
                    end
                end
                OP_ROOT: begin
                    if (w.pid < NUM_PROCESSES) begin
                        root_ok[w.pid] = w.present;
                        root_id[w.pid] = w.tid;
                    end
                end
                OP_XLATE: begin
                    if (w.pid >= NUM_PROCESSES || !root_ok[w.pid]) begin
                        r.status = STAT_NO_ROOT;
                    end else begin
                        cur = int'(root_id[w.pid]);
                        if (cur >= NUM_TABLES) r.status = STAT_BAD;
                        // top slice of the page number indexes the root table
                        for (int lvl = 0; r.status == STAT_OK && lvl < levels; lvl++) begin
                            idx  = (int'(w.page) >> (nbits * (levels - lvl - 1)))
                                   & ((1 << nbits) - 1);
                            addr = cur * SLOTS + idx;
                            r.reads = r.reads + 1'b1;
                            if (!entry_ok[addr]) begin
                                r.status = STAT_MISSING;
                            end else if (lvl + 1 < levels) begin
                                if (entry_val[addr] >= NUM_TABLES) r.status = STAT_BAD;
                                else cur = int'(entry_val[addr]);
                            end else begin
                                r.frame = entry_val[addr];
                            end
                        end
                        if (r.status != STAT_OK) r.frame = '0;
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_input(walk_word_t w);
            owed_q.push_back(apply_word(w));
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("%0t ns: %s", $time, msg);
        endtask

        task check_result(logic [1:0] st, logic [FRAME_BITS-1:0] fr, logic [READS_W-1:0] rd);
            walk_result_t exp;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected result word: status %0d frame %h reads %0d",
                                 st, fr, rd));
                return;
            end
            exp = owed_q.pop_front();
            if (st !== exp.status)
                report($sformatf("status %0d, want %0d", st, exp.status));
            if (fr !== exp.frame)
                report($sformatf("frame %h, want %h", fr, exp.frame));
            if (rd !== exp.reads)
                report($sformatf("table_reads %0d, want %0d", rd, exp.reads));
        endtask

        task report_unfinished();
            while (owed_q.size() > 0) begin
                void'(owed_q.pop_front());
                report("result word never arrived");
            end
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [CFG_W-1:0]       cfg_data;

    walk_scoreboard sb;
    bit             calm;        // no idling on either side while set
    int             words_sent;
    mapped_page_t   mapped_q [$];

    multilevel_page_table_walk i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Send one word and record it at the accepting edge
    task automatic send_word(opcode_t op, logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page,
                             logic [TID_W-1:0] tid, logic [SLOT_W-1:0] slot,
                             logic present, logic [VALUE_W-1:0] value);
        walk_word_t w;
        int gap;
        w.op      = op;
        w.pid     = pid;
        w.page    = page;
        w.tid     = tid;
        w.slot    = slot;
        w.present = present;
        w.value   = value;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, value, present, slot, tid, page, pid};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(w);
        words_sent++;
    endtask

    task automatic write_entry(logic [TID_W-1:0] tid, logic [SLOT_W-1:0] slot,
                               logic present, logic [VALUE_W-1:0] value);
        send_word(OP_WRITE, PID_W'($urandom), PAGE_W'($urandom), tid, slot, present, value);
    endtask

    task automatic set_root(logic [PID_W-1:0] pid, logic [TID_W-1:0] tid, logic present);
        send_word(OP_ROOT, pid, PAGE_W'($urandom), tid, SLOT_W'($urandom), present,
                  VALUE_W'($urandom));
    endtask

    task automatic xlate(logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page);
        send_word(OP_XLATE, pid, page, TID_W'($urandom), SLOT_W'($urandom), 1'($urandom),
                  VALUE_W'($urandom));
    endtask

    // Hold the input side until every result word is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
    endtask

    task automatic program_walk(logic [CFG_W-1:0] levels, logic [CFG_W-1:0] nbits);
        logic [CFG_IDX_W-1:0] idx [2];
        logic [CFG_W-1:0]     val [2];
        idx[0] = CFG_LEVEL_COUNT;
        idx[1] = CFG_INDEX_BITS;
        val[0] = levels;
        val[1] = nbits;
        for (int i = 0; i < 2; i++) begin
            cfg_valid <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random page bits above the part the walk uses
    function automatic logic [PAGE_W-1:0] scramble_high(logic [PAGE_W-1:0] page, int used);
        logic [31:0] hi;
        hi = $urandom;
        if (used >= PAGE_W) return page;
        return page ^ PAGE_W'(hi << used);
    endfunction

    // Build (or reuse) a path for a random page, at times with an absent or bad entry, then translate it
    task automatic build_and_walk();
        logic [PID_W-1:0]   pid;
        logic [PAGE_W-1:0]  page;
        logic [VALUE_W-1:0] nxt;
        logic               present;
        int levels, nbits, cur, idx, addr;
        mapped_page_t mp;
        levels = sb.levels_used();
        nbits  = sb.bits_used();
        pid    = PID_W'($urandom);
        page   = PAGE_W'($urandom);
        if (!sb.root_ok[pid] || $urandom_range(0, 9) == 0)
            set_root(pid, TID_W'($urandom), 1'b1);
        cur = int'(sb.root_id[pid]);
        for (int lvl = 0; lvl < levels; lvl++) begin
            idx  = (int'(page) >> (nbits * (levels - lvl - 1))) & ((1 << nbits) - 1);
            addr = cur * SLOTS + idx;
            // share an existing inner entry half the time
            if (lvl + 1 < levels && sb.entry_ok[addr] && sb.entry_val[addr] < NUM_TABLES
                && $urandom_range(0, 1) == 0) begin
                cur = int'(sb.entry_val[addr]);
                continue;
            end
            if (lvl + 1 < levels)
                nxt = ($urandom_range(0, 19) == 0) ? VALUE_W'($urandom_range(NUM_TABLES, 65535))
                                                   : VALUE_W'($urandom_range(0, NUM_TABLES - 1));
            else
                nxt = VALUE_W'($urandom);
            present = ($urandom_range(0, 24) != 0);
            write_entry(TID_W'(cur), SLOT_W'(idx), present, nxt);
            if (nxt >= NUM_TABLES) break;
            cur = int'(nxt);
        end
        repeat ($urandom_range(1, 3)) xlate(pid, scramble_high(page, levels * nbits));
        mp.pid  = pid;
        mp.page = page;
        mapped_q.push_back(mp);
        if (mapped_q.size() > 64) void'(mapped_q.pop_front());
    endtask

    // One random step of stimulus: mostly well-formed walks, the rest noise
    task automatic random_step();
        int r;
        mapped_page_t mp;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            build_and_walk();
        end else if (r < 68) begin
            xlate(PID_W'($urandom), PAGE_W'($urandom));
        end else if (r < 80 && mapped_q.size() > 0) begin
            mp = mapped_q[$urandom_range(0, mapped_q.size() - 1)];
            xlate(mp.pid, scramble_high(mp.page, sb.levels_used() * sb.bits_used()));
        end else if (r < 88) begin
            write_entry(TID_W'($urandom), SLOT_W'($urandom), 1'($urandom), VALUE_W'($urandom));
        end else if (r < 95) begin
            set_root(PID_W'($urandom), TID_W'($urandom), ($urandom_range(0, 3) != 0));
        end else begin
            send_word(OP_NONE, PID_W'($urandom), PAGE_W'($urandom), TID_W'($urandom),
                      SLOT_W'($urandom), 1'($urandom), VALUE_W'($urandom));
        end
    endtask

    // Short directed pass under the reset configuration (2 levels, 2 bits)
    task automatic directed_checks();
        xlate(4'd0, 16'h0000);                          // no root yet
        send_word(OP_NONE, 4'hF, 16'hFFFF, 6'h3F, 4'hF, 1'b1, 16'hFFFF);
        set_root(4'd15, 6'd63, 1'b1);
        set_root(4'd0, 6'd0, 1'b1);
        xlate(4'd15, 16'h0000);                         // root present, entry missing
        write_entry(6'd63, 4'd0, 1'b1, 16'd5);
        write_entry(6'd5, 4'd0, 1'b1, 16'hFFFF);
        xlate(4'd15, 16'hFFF0);                         // bits above the walk ignored
        write_entry(6'd63, 4'd3, 1'b1, 16'hFFFF);
        xlate(4'd15, 16'h000C);                         // inner entry past table count
        write_entry(6'd63, 4'd15, 1'b1, 16'd0);         // slot never reached
        write_entry(6'd5, 4'd0, 1'b0, 16'h1234);        // clear the leaf
        xlate(4'd15, 16'h0000);
        set_root(4'd15, 6'd63, 1'b0);                   // clear the root
        xlate(4'd15, 16'h0000);
        write_entry(6'd0, 4'd0, 1'b1, 16'd64);          // first value past table count
        xlate(4'd0, 16'h0000);
        write_entry(6'd0, 4'd1, 1'b1, 16'd63);
        write_entry(6'd63, 4'd2, 1'b1, 16'h0000);
        xlate(4'd0, 16'h0006);                          // good walk to frame zero
    endtask

    // Result side: random stalls, check each accepted word
    initial begin
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata[FRAME_BITS-1:0],
                                m_tdata[FRAME_BITS +: READS_W]);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    // Stimulus and end of run
    initial begin
        logic [CFG_W-1:0] lvl_set  [10];
        logic [CFG_W-1:0] bits_set [10];
        lvl_set  = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd1, 3'd4, 3'd2, 3'd5, 3'd6};
        bits_set = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd4, 3'd1, 3'd3, 3'd2, 3'd5};
        sb         = new();
        calm       = 1'b0;
        words_sent = 0;
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= OP_NONE;
        cfg_valid  <= 1'b0;
        cfg_addr   <= CFG_LEVEL_COUNT;
        cfg_data   <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        directed_checks();
        while (words_sent < 130) random_step();
        drain_results();

        // Each phase: new walk shape, then random words
        for (int ph = 0; ph < 10; ph++) begin
            calm = (ph == 3) || ($urandom_range(0, 4) == 0);
            program_walk(lvl_set[ph], bits_set[ph]);
            while (words_sent < 130 + 117 * (ph + 1)) begin
                random_step();
                if ($urandom_range(0, 99) == 0) drain_results();
            end
            drain_results();
        end

        repeat (20) @(posedge aclk);
        sb.report_unfinished();
        if (sb.errors == 0)
            $display("multilevel_page_table_walk: match");
        else
            $display("multilevel_page_table_walk: mismatch");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("multilevel_page_table_walk: mismatch");
        $finish;
    end

endmodule
